// File: rtl/core/frustum_cull_test_macros.svh
// Assertion macros for the frustum cull test block.
// Used by the top level only; no other dependencies.
`ifndef FRUSTUM_CULL_TEST_MACROS_SVH
`define FRUSTUM_CULL_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum_cull_test: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum_cull_test: next-cycle check failed");

`endif

// File: rtl/core/fct_pkg.sv
// Shared types, codes and helpers for the frustum cull test block.
// No dependencies.
package fct_pkg;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_POINT  = 2'd1;
   localparam logic [1:0] ACT_SPHERE = 2'd2;
   localparam logic [1:0] ACT_BOX    = 2'd3;

   localparam int MAT_W     = 32;
   localparam int COEF_W    = 33;
   localparam int MAT_DEPTH = 16;
   localparam int PLN_DEPTH = 24;
   localparam int MUL_A_W   = 36;
   localparam int MUL_B_W   = 34;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SQ_W      = 64;
   localparam int ROOT_W    = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_SQ,
      ST_SQRT,
      ST_PL_RD,
      ST_PL_MUL,
      ST_PL_CHK,
      ST_DONE
   } state_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      mag33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

endpackage

// File: rtl/core/fct_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on nothing.
interface fct_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [3:0]         elem_index;
   logic signed [31:0] elem_value;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] center_z;
   logic [30:0]        radius;
   logic signed [31:0] extent_x;
   logic signed [31:0] extent_y;
   logic signed [31:0] extent_z;
   modport source (output valid, action, elem_index, elem_value, center_x, center_y,
                   center_z, radius, extent_x, extent_y, extent_z, input ready);
   modport sink   (input valid, action, elem_index, elem_value, center_x, center_y,
                   center_z, radius, extent_x, extent_y, extent_z, output ready);
endinterface

interface fct_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

// File: rtl/core/fct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/fct_sqrt.sv
// Iterative truncating square root, one result bit per cycle.
// Depends on fct_pkg.
module fct_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fct_pkg::SQ_W-1:0]    radicand,
   output logic                        done,
   output logic [fct_pkg::ROOT_W-1:0]  root
);
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [fct_pkg::SQ_W-1:0] n_ff, n_in;
   logic [fct_pkg::SQ_W-1:0] r_ff, r_in;
   logic [fct_pkg::SQ_W-1:0] bit_ff, bit_in;
   logic [fct_pkg::SQ_W-1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      trial   = r_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         n_in    = radicand;
         r_in    = '0;
         bit_in  = {2'b01, {(fct_pkg::SQ_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[fct_pkg::ROOT_W-1:0];
endmodule

// File: rtl/core/frustum_cull_test.sv
// Frustum cull test: six clip planes built from a 4x4 view-projection matrix.
// req_bus carries items: action 0 loads one matrix element (column*4+component)
//   and rebuilds that column's coefficient in all six planes; no response.
//   Actions 1/2/3 test a point, sphere or box; each yields one rsp_bus item
//   whose inside_res is 1 when the shape passes all six planes.
// Sequence: a load reads the four matrix entries of its column, then writes the
//   six plane entries of that column. A point or sphere test walks the six planes
//   in turn: it reads four coefficients, multiplies and accumulates them against
//   the center, then checks the sign. A box test first squares the three extents
//   and takes the bit-serial square root of their sum, then adds one multiply per
//   plane. The next item is accepted once the sequencer is back in idle. Plane data
//   comes through the single read port of the plane RAM; one multiplier is shared.
// One item is worked at a time; req_bus.ready is high when the sequencer idles,
//   even while an earlier response still waits in the output register.
// A stalled receiver holds the response; a finished query then waits in its
//   last state until the output register frees up.
// Reset (synchronous, active high) clears the sequencer and the valid bits of
//   both RAMs, so all matrix elements and planes read as zero right away: points
//   and spheres then pass, boxes fail. Depends on fct_pkg, fct_if, fct_ram,
//   fct_sqrt and frustum_cull_test_macros.svh.
`include "frustum_cull_test_macros.svh"

module frustum_cull_test #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   fct_req_if.sink       req_bus,
   fct_rsp_if.source     rsp_bus
);
   localparam int ACC_W = (FRAC_BITS + 40 > 74) ? FRAC_BITS + 40 : 74;

   fct_pkg::state_type state_ff, state_in;

   // captured request payload
   logic [1:0]         act_ff;
   logic [3:0]         idx_ff;
   logic signed [31:0] val_ff, cx_ff, cy_ff, cz_ff, ex_ff, ey_ff, ez_ff;
   logic [30:0]        rad_ff;

   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] plane_ff, plane_in;
   logic signed [fct_pkg::COEF_W-1:0] coef_ff [4];
   logic signed [fct_pkg::COEF_W-1:0] coef_in [4];
   logic       rd_pend_ff, rd_pend_in;
   logic [1:0] rd_slot_ff;
   logic       rd_vld_ff, rd_vld_in;
   logic [fct_pkg::MAT_DEPTH-1:0] mat_vld_ff, mat_vld_in;
   logic [fct_pkg::PLN_DEPTH-1:0] pln_vld_ff, pln_vld_in;

   logic signed [fct_pkg::PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic [fct_pkg::SQ_W-1:0]          sq_ff, sq_in, sq_sum;
   logic [fct_pkg::COEF_W-1:0]        size_ff, size_in;
   logic                              inside_ff, inside_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_inside_ff;
   logic                              rsp_load;

   // memory ports
   logic                              mat_we;
   logic [3:0]                        mat_waddr, mat_raddr;
   logic [fct_pkg::MAT_W-1:0]         mat_rdata;
   logic                              pln_we;
   logic [4:0]                        pln_waddr, pln_raddr;
   logic [fct_pkg::COEF_W-1:0]        pln_wdata, pln_rdata;
   logic signed [fct_pkg::COEF_W-1:0] rd_data_eff;

   logic signed [fct_pkg::MUL_A_W-1:0] mul_a;
   logic signed [fct_pkg::MUL_B_W-1:0] mul_b;
   logic signed [fct_pkg::COEF_W-1:0]  pl_w, pl_a;
   logic signed [ACC_W-1:0]            const_term;
   logic [fct_pkg::MUL_A_W-1:0]        abs_sum;
   logic [31:0]                        sq_mag;
   logic [2:0]                         last_mul;
   logic                               is_box;
   logic                               sqrt_start, sqrt_done;
   logic [fct_pkg::ROOT_W-1:0]         sqrt_root;
   logic                               req_fire;

   fct_ram #(.WIDTH(fct_pkg::MAT_W), .DEPTH(fct_pkg::MAT_DEPTH)) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (val_ff),
      .rd_addr (mat_raddr),
      .rd_data (mat_rdata)
   );

   fct_ram #(.WIDTH(fct_pkg::COEF_W), .DEPTH(fct_pkg::PLN_DEPTH)) u_pln_ram (
      .clock   (clock),
      .wr_en   (pln_we),
      .wr_addr (pln_waddr),
      .wr_data (pln_wdata),
      .rd_addr (pln_raddr),
      .rd_data (pln_rdata)
   );

   fct_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_sum),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_bus.ready  = (state_ff == fct_pkg::ST_IDLE);
   assign req_fire       = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.inside_res = rsp_inside_ff;

   assign is_box   = (act_ff == fct_pkg::ACT_BOX);
   assign last_mul = is_box ? 3'd4 : 3'd3;
   assign sq_sum   = sq_ff + prod_ff[fct_pkg::SQ_W-1:0];

   // Entries never written since reset read as zero.
   always_comb begin
      if (!rd_vld_ff) begin
         rd_data_eff = '0;
      end else if (state_ff == fct_pkg::ST_LD_RD) begin
         rd_data_eff = fct_pkg::COEF_W'(signed'(mat_rdata));
      end else begin
         rd_data_eff = signed'(pln_rdata);
      end
   end

   assign pl_w = coef_ff[3];
   assign pl_a = coef_ff[cnt_ff[2:1]];
   assign const_term = (ACC_W'(coef_ff[3])
                        + ((act_ff == fct_pkg::ACT_SPHERE) ?
                           signed'(ACC_W'(rad_ff)) : ACC_W'(0))) <<< FRAC_BITS;
   // Largest corner score: the corner sign pattern follows the coefficient signs.
   assign abs_sum = fct_pkg::MUL_A_W'(fct_pkg::mag33(coef_ff[0]))
                  + fct_pkg::MUL_A_W'(fct_pkg::mag33(coef_ff[1]))
                  + fct_pkg::MUL_A_W'(fct_pkg::mag33(coef_ff[2]));

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_mag = fct_pkg::mag32(ex_ff);
         2'd1:    sq_mag = fct_pkg::mag32(ey_ff);
         default: sq_mag = fct_pkg::mag32(ez_ff);
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      plane_in   = plane_ff;
      coef_in    = coef_ff;
      rd_pend_in = 1'b0;
      acc_in     = acc_ff;
      sq_in      = sq_ff;
      size_in    = size_ff;
      inside_in  = inside_ff;
      mat_vld_in = mat_vld_ff;
      pln_vld_in = pln_vld_ff;
      mat_we     = 1'b0;
      pln_we     = 1'b0;
      mat_waddr  = idx_ff;
      mat_raddr  = {idx_ff[3:2], cnt_ff[1:0]};
      pln_raddr  = {plane_ff, cnt_ff[1:0]};
      pln_waddr  = {cnt_ff, idx_ff[3:2]};
      pln_wdata  = cnt_ff[0] ? pl_w - pl_a : pl_w + pl_a;
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      rsp_load   = 1'b0;

      // read data lands in the cycle after the address; the element being
      // loaded is forwarded over whatever the RAM returns
      if (rd_pend_ff) begin
         if (state_ff == fct_pkg::ST_LD_RD && rd_slot_ff == idx_ff[1:0]) begin
            coef_in[rd_slot_ff] = fct_pkg::COEF_W'(val_ff);
         end else begin
            coef_in[rd_slot_ff] = rd_data_eff;
         end
      end

      case (state_ff)
         fct_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               cnt_in    = '0;
               plane_in  = '0;
               inside_in = 1'b1;
               sq_in     = '0;
               case (req_bus.action)
                  fct_pkg::ACT_LOAD: state_in = fct_pkg::ST_LD_RD;
                  fct_pkg::ACT_BOX:  state_in = fct_pkg::ST_SQ;
                  default:           state_in = fct_pkg::ST_PL_RD;
               endcase
            end
         end
         fct_pkg::ST_LD_RD: begin
            if (cnt_ff == 3'd0) begin
               mat_we = 1'b1;
               mat_vld_in[idx_ff] = 1'b1;
            end
            if (!cnt_ff[2]) begin
               rd_pend_in = 1'b1;
               cnt_in     = cnt_ff + 3'd1;
            end else begin
               cnt_in   = '0;
               state_in = fct_pkg::ST_LD_WR;
            end
         end
         fct_pkg::ST_LD_WR: begin
            pln_we = 1'b1;
            pln_vld_in[pln_waddr] = 1'b1;
            if (cnt_ff == 3'd5) begin
               state_in = fct_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         fct_pkg::ST_SQ: begin
            // squared length wraps at 64 bits, as the root unit expects
            mul_a = fct_pkg::MUL_A_W'(sq_mag);
            mul_b = fct_pkg::MUL_B_W'(sq_mag);
            if (cnt_ff != 3'd0) begin
               sq_in = sq_sum;
            end
            if (cnt_ff == 3'd3) begin
               sqrt_start = 1'b1;
               state_in   = fct_pkg::ST_SQRT;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         fct_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               size_in  = fct_pkg::COEF_W'(sqrt_root);
               cnt_in   = '0;
               state_in = fct_pkg::ST_PL_RD;
            end
         end
         fct_pkg::ST_PL_RD: begin
            if (!cnt_ff[2]) begin
               rd_pend_in = 1'b1;
               cnt_in     = cnt_ff + 3'd1;
            end else begin
               cnt_in   = '0;
               state_in = fct_pkg::ST_PL_MUL;
            end
         end
         fct_pkg::ST_PL_MUL: begin
            case (cnt_ff)
               3'd0: begin
                  mul_a = fct_pkg::MUL_A_W'(coef_ff[0]);
                  mul_b = fct_pkg::MUL_B_W'(cx_ff);
               end
               3'd1: begin
                  mul_a = fct_pkg::MUL_A_W'(coef_ff[1]);
                  mul_b = fct_pkg::MUL_B_W'(cy_ff);
               end
               3'd2: begin
                  mul_a = fct_pkg::MUL_A_W'(coef_ff[2]);
                  mul_b = fct_pkg::MUL_B_W'(cz_ff);
               end
               default: begin
                  mul_a = signed'(abs_sum);
                  mul_b = signed'(fct_pkg::MUL_B_W'(size_ff));
               end
            endcase
            if (cnt_ff == 3'd0) begin
               acc_in = const_term;
            end else begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            if (cnt_ff == last_mul) begin
               state_in = fct_pkg::ST_PL_CHK;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         fct_pkg::ST_PL_CHK: begin
            if (is_box) begin
               if (acc_ff[ACC_W-1] || acc_ff == '0) begin
                  inside_in = 1'b0;
               end
            end else if (acc_ff[ACC_W-1]) begin
               inside_in = 1'b0;
            end
            cnt_in = '0;
            if (plane_ff == 3'd5) begin
               state_in = fct_pkg::ST_DONE;
            end else begin
               plane_in = plane_ff + 3'd1;
               state_in = fct_pkg::ST_PL_RD;
            end
         end
         fct_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = fct_pkg::ST_IDLE;
            end
         end
         default: state_in = fct_pkg::ST_IDLE;
      endcase
   end

   assign rd_vld_in = (state_ff == fct_pkg::ST_LD_RD) ? mat_vld_ff[mat_raddr]
                                                      : pln_vld_ff[pln_raddr];
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fct_pkg::ST_IDLE;
         cnt_ff       <= '0;
         plane_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         mat_vld_ff   <= '0;
         pln_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         plane_ff     <= plane_in;
         rd_pend_ff   <= rd_pend_in;
         mat_vld_ff   <= mat_vld_in;
         pln_vld_ff   <= pln_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         act_ff <= req_bus.action;
         idx_ff <= req_bus.elem_index;
         val_ff <= req_bus.elem_value;
         cx_ff  <= req_bus.center_x;
         cy_ff  <= req_bus.center_y;
         cz_ff  <= req_bus.center_z;
         rad_ff <= req_bus.radius;
         ex_ff  <= req_bus.extent_x;
         ey_ff  <= req_bus.extent_y;
         ez_ff  <= req_bus.extent_z;
      end
      if (rsp_load) begin
         rsp_inside_ff <= inside_ff;
      end
      rd_slot_ff <= cnt_ff[1:0];
      rd_vld_ff  <= rd_vld_in;
      coef_ff    <= coef_in;
      prod_ff    <= mul_a * mul_b;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      size_ff    <= size_in;
      inside_ff  <= inside_in;
   end

   // a load goes straight to the matrix read phase
   `FCT_ASSERT_NEXT(a_load_starts, clock, reset,
      req_fire && req_bus.action == fct_pkg::ACT_LOAD, state_ff == fct_pkg::ST_LD_RD)
   // only six planes are ever walked
   `FCT_ASSERT_NOW(a_plane_range, clock, reset,
      state_ff == fct_pkg::ST_PL_CHK, plane_ff <= 3'd5)
   // the root unit reports only while the sequencer waits for it
   `FCT_ASSERT_NOW(a_sqrt_owner, clock, reset, sqrt_done, state_ff == fct_pkg::ST_SQRT)
   // a finished query always lands in the output register
   `FCT_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid_ff)

endmodule

// File: sim/tb_frustum_cull_test.sv
// Self-checking bench for frustum_cull_test: matrix loads, point/sphere/box queries.
// Depends on fct_pkg, the fct_req_if/fct_rsp_if interfaces and the block itself.
module tb_frustum_cull_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;

   logic clock;
   logic reset;

   fct_req_if req_bus ();
   fct_rsp_if rsp_bus ();

   frustum_cull_test #(.FRAC_BITS(FRAC)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // One request item as the driver sees it. wait_drain holds the item back
   // until every outstanding response has been returned.
   typedef struct {
      logic [1:0]         action;
      logic [3:0]         elem_index;
      logic signed [31:0] elem_value;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        radius;
      logic signed [31:0] extent_x;
      logic signed [31:0] extent_y;
      logic signed [31:0] extent_z;
      bit                 wait_drain;
   } cull_item_type;

   cull_item_type pending_items[$];
   bit            inside_expected[$];

   // Shadow copy of the block's matrix and clip planes (plane*4 + column).
   logic signed [31:0] shadow_matrix[16];
   logic signed [32:0] shadow_plane[24];

   int n_errors   = 0;
   int n_checked  = 0;
   int n_loads    = 0;
   int n_queries[4] = '{0, 0, 0, 0};
   int n_inside   = 0;
   bit stim_done  = 0;

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // Truncating integer square root of a 64-bit value.
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Exact plane distance scaled by 2^(2*FRAC): x/y/z terms plus (w+extra)<<FRAC.
   function automatic logic signed [127:0] plane_dist(input int p,
                                                      input logic signed [63:0] x,
                                                      input logic signed [63:0] y,
                                                      input logic signed [63:0] z,
                                                      input logic signed [63:0] extra);
      logic signed [127:0] acc;
      logic signed [127:0] wterm;
      acc = 128'(shadow_plane[p*4 + 0]) * 128'(x);
      acc = acc + 128'(shadow_plane[p*4 + 1]) * 128'(y);
      acc = acc + 128'(shadow_plane[p*4 + 2]) * 128'(z);
      wterm = 128'(shadow_plane[p*4 + 3]) + 128'(extra);
      acc = acc + (wterm <<< FRAC);
      return acc;
   endfunction

   // Applies one accepted item to the shadow state; queues the inside flag
   // for queries.
   task automatic cull_predict(input cull_item_type it);
      int                  col;
      logic signed [33:0]  w;
      logic signed [33:0]  a;
      logic signed [63:0]  rad;
      logic signed [63:0]  sz;
      longint unsigned     mx, my, mz, sq;
      bit                  in_frustum;
      bit                  any_pos;
      logic signed [63:0]  px, py, pz;
      if (it.action == fct_pkg::ACT_LOAD) begin
         col = it.elem_index >> 2;
         shadow_matrix[it.elem_index] = it.elem_value;
         for (int p = 0; p < 6; p++) begin
            w = 34'(shadow_matrix[col*4 + 3]);
            a = 34'(shadow_matrix[col*4 + (p >> 1)]);
            shadow_plane[p*4 + col] = 33'((p & 1) ? w - a : w + a);
         end
         n_loads++;
         return;
      end
      in_frustum = 1'b1;
      if (it.action == fct_pkg::ACT_POINT || it.action == fct_pkg::ACT_SPHERE) begin
         rad = (it.action == fct_pkg::ACT_SPHERE) ? 64'(it.radius) : 64'sd0;
         for (int p = 0; p < 6; p++)
            if (plane_dist(p, 64'(it.center_x), 64'(it.center_y), 64'(it.center_z),
                           rad) < 0)
               in_frustum = 1'b0;
      end else begin
         mx = 64'(fct_pkg::mag32(it.extent_x));
         my = 64'(fct_pkg::mag32(it.extent_y));
         mz = 64'(fct_pkg::mag32(it.extent_z));
         sq = mx*mx + my*my + mz*mz;
         sz = 64'(int_sqrt(sq));
         for (int p = 0; p < 6; p++) begin
            any_pos = 1'b0;
            for (int k = 0; k < 8; k++) begin
               px = (k & 1) ? 64'(it.center_x) + sz : 64'(it.center_x) - sz;
               py = (k & 2) ? 64'(it.center_y) + sz : 64'(it.center_y) - sz;
               pz = (k & 4) ? 64'(it.center_z) + sz : 64'(it.center_z) - sz;
               if (plane_dist(p, px, py, pz, 64'sd0) > 0) any_pos = 1'b1;
            end
            if (!any_pos) in_frustum = 1'b0;
         end
      end
      n_queries[it.action]++;
      inside_expected.push_back(in_frustum);
   endtask

   // ---------------------------------------------------------------------
   // Random gaps: mostly none or short, now and then long. A quiet mode runs
   // stretches with no gaps at all.
   // ---------------------------------------------------------------------
   bit quiet_mode = 0;

   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) quiet_mode <= ~quiet_mode;
   end

   // ---------------------------------------------------------------------
   // Driver
   // ---------------------------------------------------------------------
   int req_gap = 0;

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.action     = fct_pkg::ACT_LOAD;
      req_bus.elem_index = '0;
      req_bus.elem_value = '0;
      req_bus.center_x   = '0;
      req_bus.center_y   = '0;
      req_bus.center_z   = '0;
      req_bus.radius     = '0;
      req_bus.extent_x   = '0;
      req_bus.extent_y   = '0;
      req_bus.extent_z   = '0;
      rsp_bus.ready      = 1'b0;
   end

   always @(posedge clock) begin
      cull_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            cull_predict(pending_items.pop_front());
            req_gap = pick_gap();
         end
         // Slot is free when nothing is offered or the offer was just taken.
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].wait_drain && inside_expected.size() > 0)) begin
               nxt = pending_items[0];
               req_bus.valid      <= 1'b1;
               req_bus.action     <= nxt.action;
               req_bus.elem_index <= nxt.elem_index;
               req_bus.elem_value <= nxt.elem_value;
               req_bus.center_x   <= nxt.center_x;
               req_bus.center_y   <= nxt.center_y;
               req_bus.center_z   <= nxt.center_z;
               req_bus.radius     <= nxt.radius;
               req_bus.extent_x   <= nxt.extent_x;
               req_bus.extent_y   <= nxt.extent_y;
               req_bus.extent_z   <= nxt.extent_z;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure, in-order compare
   // ---------------------------------------------------------------------
   int rsp_gap = 0;

   always @(posedge clock) begin
      bit exp_inside;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (inside_expected.size() == 0) begin
               $display("%0t ERROR unexpected response: expected none, actual inside_res=%0b",
                        $time, rsp_bus.inside_res);
               n_errors++;
            end else begin
               exp_inside = inside_expected.pop_front();
               n_checked++;
               if (exp_inside) n_inside++;
               if (rsp_bus.inside_res !== exp_inside) begin
                  $display("%0t ERROR inside_res mismatch: expected %0b, actual %0b",
                           $time, exp_inside, rsp_bus.inside_res);
                  n_errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Coordinates: mostly within +-8.0, sometimes anything at all.
   function automatic logic signed [31:0] rand_coord();
      int v;
      if ($urandom_range(0, 9) < 8) begin
         v = $urandom_range(0, 32'h0010_0000);
         return 32'(v - 32'h0008_0000);
      end
      return 32'($urandom);
   endfunction

   // Matrix elements: common projection-like values plus some noise.
   function automatic logic signed [31:0] rand_elem();
      case ($urandom_range(0, 9))
         0, 1:    return 32'sh0;
         2:       return 32'sh0001_0000;
         3:       return -32'sh0001_0000;
         4:       return 32'sh0000_8000;
         5:       return 32'(-32'sh0000_8000);
         6, 7, 8: return 32'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic cull_item_type mk_load(input int idx, input logic signed [31:0] v);
      cull_item_type it;
      it = '{default: '0};
      it.action     = fct_pkg::ACT_LOAD;
      it.elem_index = 4'(idx);
      it.elem_value = v;
      return it;
   endfunction

   function automatic cull_item_type mk_query(input logic [1:0] act,
                                              input logic signed [31:0] x,
                                              input logic signed [31:0] y,
                                              input logic signed [31:0] z,
                                              input logic [30:0] r,
                                              input logic signed [31:0] ex,
                                              input logic signed [31:0] ey,
                                              input logic signed [31:0] ez);
      cull_item_type it;
      it = '{default: '0};
      it.action   = act;
      it.center_x = x;
      it.center_y = y;
      it.center_z = z;
      it.radius   = r;
      it.extent_x = ex;
      it.extent_y = ey;
      it.extent_z = ez;
      return it;
   endfunction

   // Everything random, unused fields included.
   function automatic cull_item_type rand_noise();
      cull_item_type it;
      it.action     = 2'($urandom);
      it.elem_index = 4'($urandom);
      it.elem_value = 32'($urandom);
      it.center_x   = 32'($urandom);
      it.center_y   = 32'($urandom);
      it.center_z   = 32'($urandom);
      it.radius     = 31'($urandom);
      it.extent_x   = 32'($urandom);
      it.extent_y   = 32'($urandom);
      it.extent_z   = 32'($urandom);
      it.wait_drain = 1'b0;
      return it;
   endfunction

   function automatic cull_item_type rand_query();
      cull_item_type it;
      logic [1:0] act;
      act = 2'($urandom_range(1, 3));
      it = mk_query(act, rand_coord(), rand_coord(), rand_coord(),
                    ($urandom_range(0, 9) < 8) ? 31'($urandom_range(0, 32'h0004_0000))
                                               : 31'($urandom),
                    rand_coord(), rand_coord(), rand_coord());
      // Unused fields carry garbage; the block must ignore them.
      it.elem_index = 4'($urandom);
      it.elem_value = 32'($urandom);
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE   = 32'sh0001_0000;

   initial begin
      int total;
      int n_ld;
      int n_q;
      int order[16];
      cull_item_type it;

      for (int i = 0; i < 16; i++) shadow_matrix[i] = '0;
      for (int i = 0; i < 24; i++) shadow_plane[i] = '0;

      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero matrix means points/spheres inside and boxes outside.
      pending_items.push_back(mk_query(fct_pkg::ACT_POINT, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(mk_query(fct_pkg::ACT_SPHERE, S_MAX, S_MIN, S_MAX,
                                       31'h7FFF_FFFF, 0, 0, 0));
      pending_items.push_back(mk_query(fct_pkg::ACT_BOX, 0, 0, 0, 0, 0, 0, 0));
      // Identity matrix: planes x+-w, y+-w, z+-w, i.e. the unit cube.
      for (int i = 0; i < 4; i++) pending_items.push_back(mk_load(i*5, ONE));
      pending_items.push_back(mk_query(fct_pkg::ACT_POINT, ONE, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(mk_query(fct_pkg::ACT_POINT, ONE + 1, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(mk_query(fct_pkg::ACT_SPHERE, 2*ONE, 0, 0, 31'(ONE),
                                       0, 0, 0));
      pending_items.push_back(mk_query(fct_pkg::ACT_SPHERE, 2*ONE + 1, 0, 0, 31'(ONE),
                                       0, 0, 0));
      pending_items.push_back(mk_query(fct_pkg::ACT_BOX, 0, 0, 3*ONE, 0, ONE, ONE, ONE));
      pending_items.push_back(mk_query(fct_pkg::ACT_BOX, S_MIN, S_MAX, S_MIN, 0,
                                       S_MIN, S_MIN, S_MIN));
      pending_items.push_back(mk_query(fct_pkg::ACT_BOX, S_MAX, S_MAX, S_MAX, 0,
                                       S_MAX, S_MIN, S_MAX));
      // Extreme matrix values, then drain before continuing.
      pending_items.push_back(mk_load(3, S_MIN));
      pending_items.push_back(mk_load(0, S_MAX));
      pending_items.push_back(mk_load(15, S_MAX));
      pending_items.push_back(mk_load(14, S_MIN));
      pending_items.push_back(mk_query(fct_pkg::ACT_POINT, S_MIN, S_MIN, S_MIN,
                                       0, 0, 0, 0));
      pending_items.push_back(mk_query(fct_pkg::ACT_SPHERE, S_MAX, S_MAX, S_MAX,
                                       31'h7FFF_FFFF, 0, 0, 0));
      it = mk_query(fct_pkg::ACT_BOX, S_MIN, S_MAX, S_MIN, 0, S_MAX, S_MAX, S_MAX);
      it.wait_drain = 1'b1;
      pending_items.push_back(it);
      total = pending_items.size();

      // Random scenes: rebuild some or all of the matrix, then a burst of
      // queries against it. A tenth of the queries are pure noise.
      while (total < 1000) begin
         n_ld = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 16;
         for (int i = 0; i < 16; i++) order[i] = i;
         order.shuffle();
         for (int i = 0; i < n_ld; i++) begin
            it = mk_load(order[i], rand_elem());
            it.center_x = 32'($urandom);
            it.radius   = 31'($urandom);
            pending_items.push_back(it);
         end
         n_q = $urandom_range(4, 16);
         for (int i = 0; i < n_q; i++) begin
            it = ($urandom_range(0, 9) == 0) ? rand_noise() : rand_query();
            // Occasionally make the sender wait for a full drain.
            if ($urandom_range(0, 49) == 0) it.wait_drain = 1'b1;
            pending_items.push_back(it);
         end
         total += n_ld + n_q;
      end

      wait (pending_items.size() == 0);
      wait (inside_expected.size() == 0);
      repeat (200) @(posedge clock);
      stim_done = 1'b1;

      $display("Covered %0d items: %0d loads, %0d point / %0d sphere / %0d box queries.",
               total, n_loads, n_queries[fct_pkg::ACT_POINT],
               n_queries[fct_pkg::ACT_SPHERE], n_queries[fct_pkg::ACT_BOX]);
      $display("Responses checked: %0d (%0d inside), errors: %0d",
               n_checked, n_inside, n_errors);
      if (n_errors == 0 && inside_expected.size() == 0) begin
         $display("frustum_cull_test verification clean");
      end else begin
         if (inside_expected.size() != 0)
            $display("%0t ERROR %0d responses never arrived", $time, inside_expected.size());
         $display("frustum_cull_test verification failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #20ms;
      if (!stim_done) begin
         $display("%0t ERROR timeout with %0d items pending, %0d responses outstanding",
                  $time, pending_items.size(), inside_expected.size());
         $display("frustum_cull_test verification failed");
         $finish;
      end
   end

endmodule
